[rtl/core/pal_pkg.sv]
// ----------------------------------------------------------------------------
// pal_pkg
// Shared widths, types and constants for the point-along-line projector.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 8;
  localparam int GIVEN_W     = 25;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int RAD_W       = SQ_W + 2 * FRAC_BITS;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int LEN_W       = (ROOT_W > GIVEN_W) ? ROOT_W : GIVEN_W;
  localparam int PA_W        = COORD_WIDTH + LEN_W + 1;
  localparam int PT_W        = COORD_WIDTH + DIFF_W;
  localparam int PTS_W       = PT_W + FRAC_BITS;
  localparam int NUM_W       = ((PA_W > PTS_W) ? PA_W : PTS_W) + 1;
  localparam int QW          = COORD_WIDTH + 1;
  localparam int DIV_LAT     = QW + 2;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Per-item data that rides alongside the square root pipeline.
  typedef struct packed {
    logic                          action;
    logic [GIVEN_W-1:0]            given;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] t;
    logic signed [DIFF_W-1:0]      dx;
    logic signed [DIFF_W-1:0]      dy;
  } side_t;

endpackage

[rtl/core/pal_isqrt.sv]
// ----------------------------------------------------------------------------
// pal_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pal_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [pal_pkg::RAD_W-1:0]  rad,
  input  pal_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [pal_pkg::ROOT_W-1:0] root,
  output pal_pkg::side_t             out_side
);

  localparam int RW = pal_pkg::ROOT_W;

  logic                       v     [0:RW];
  logic [pal_pkg::RAD_W-1:0]  n_q   [0:RW];
  logic [RW+1:0]              rem_q [0:RW];
  logic [RW-1:0]              r_q   [0:RW];
  pal_pkg::side_t             sd_q  [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    n_q[0]   <= rad;
    rem_q[0] <= '0;
    r_q[0]   <= '0;
    sd_q[0]  <= in_side;
  end

  for (genvar s = 0; s < RW; s++) begin : g_step
    localparam int I = RW - 1 - s;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ge;

    // Bring down the next two radicand bits and try appending a one.
    always_comb begin
      rem_sh = {rem_q[s][RW-1:0], n_q[s][2*I+1 -: 2]};
      trial  = {r_q[s], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v[s];
      end
      n_q[s+1]   <= n_q[s];
      rem_q[s+1] <= ge ? (rem_sh - trial) : rem_sh;
      r_q[s+1]   <= {r_q[s][RW-2:0], ge};
      sd_q[s+1]  <= sd_q[s];
    end
  end

  assign out_valid = v[RW];
  assign root      = r_q[RW];
  assign out_side  = sd_q[RW];

endmodule

[rtl/core/pal_div.sv]
// ----------------------------------------------------------------------------
// pal_div
// Pipelined restoring divider with signed saturation of the quotient.
// ----------------------------------------------------------------------------
module pal_div (
  input  logic                                   clk,
  input  logic                                   neg,
  input  logic [pal_pkg::NUM_W-1:0]              mag,
  input  logic [pal_pkg::LEN_W-1:0]              len,
  output logic signed [pal_pkg::COORD_WIDTH-1:0] coord,
  output logic                                   sat
);

  localparam int NW = pal_pkg::NUM_W;
  localparam int Q  = pal_pkg::QW;
  localparam int CW = pal_pkg::COORD_WIDTH;

  logic                      ovf_q [0:Q];
  logic                      neg_q [0:Q];
  logic [NW-1:0]             rem_q [0:Q];
  logic [pal_pkg::LEN_W-1:0] len_q [0:Q];
  logic [Q-1:0]              quo_q [0:Q];
  logic [NW-1:0]             len_ext;

  // A quotient that needs more than Q bits is flagged once, up front.
  assign len_ext = NW'(len);

  always_ff @(posedge clk) begin
    ovf_q[0] <= ((mag >> Q) >= len_ext);
    neg_q[0] <= neg;
    rem_q[0] <= mag;
    len_q[0] <= len;
    quo_q[0] <= '0;
  end

  for (genvar s = 0; s < Q; s++) begin : g_step
    localparam int K = Q - 1 - s;
    logic [NW-1:0] sub;
    logic          ge;

    always_comb begin
      sub = NW'(len_q[s]) << K;
      ge  = (rem_q[s] >= sub);
    end

    always_ff @(posedge clk) begin
      ovf_q[s+1] <= ovf_q[s];
      neg_q[s+1] <= neg_q[s];
      rem_q[s+1] <= ge ? (rem_q[s] - sub) : rem_q[s];
      len_q[s+1] <= len_q[s];
      quo_q[s+1] <= {quo_q[s][Q-2:0], ge};
    end
  end

  localparam logic [Q-1:0] HALF = Q'(1) << (CW - 1);

  always_ff @(posedge clk) begin
    if (!neg_q[Q]) begin
      if (ovf_q[Q] || (quo_q[Q] > (HALF - Q'(1)))) begin
        coord <= pal_pkg::COORD_MAX;
        sat   <= 1'b1;
      end else begin
        coord <= quo_q[Q][CW-1:0];
        sat   <= 1'b0;
      end
    end else begin
      if (ovf_q[Q] || (quo_q[Q] > HALF)) begin
        coord <= pal_pkg::COORD_MIN;
        sat   <= 1'b1;
      end else begin
        coord <= CW'(Q'(0) - quo_q[Q]);
        sat   <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/point_along_line_projection_top.sv]
// ----------------------------------------------------------------------------
// point_along_line_projection_top
// Point at a signed distance from A toward B, fully pipelined.
// ----------------------------------------------------------------------------
// One item may be started in every clock cycle; busy is never raised. Each
// beat passes through the one-bit-per-stage square root (26 stages) and the
// two parallel one-bit-per-stage dividers (19 stages) on its way to done.
// Results are in order and are shown for exactly one cycle, so the receiver
// must take every beat as it comes. With action 0 the length is the exact
// truncated Q.8 root of the squared distance; with action 1 it is
// given_length. A zero length returns A with zero_length set, and a
// coordinate outside the signed range is clamped with saturated set.
module point_along_line_projection_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   action,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] start_x,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] start_y,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] end_x,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] end_y,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] travel,
  input  logic [pal_pkg::GIVEN_W-1:0]            given_length,
  output logic                                   done,
  output logic signed [pal_pkg::COORD_WIDTH-1:0] point_x,
  output logic signed [pal_pkg::COORD_WIDTH-1:0] point_y,
  output logic                                   zero_length,
  output logic                                   saturated
);

  localparam int CW = pal_pkg::COORD_WIDTH;
  localparam int FB = pal_pkg::FRAC_BITS;
  localparam int DW = pal_pkg::DIFF_W;
  localparam int LW = pal_pkg::LEN_W;
  localparam int NW = pal_pkg::NUM_W;
  localparam int DL = pal_pkg::DIV_LAT;

  // The pipeline never stalls, so a new beat is always welcome.
  assign busy = 1'b0;

  // Stage A: capture the beat and form the differences B - A.
  logic           va;
  pal_pkg::side_t sa;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= start;
    end
    sa.action <= action;
    sa.given  <= given_length;
    sa.ax     <= start_x;
    sa.ay     <= start_y;
    sa.t      <= travel;
    sa.dx     <= DW'(end_x) - DW'(start_x);
    sa.dy     <= DW'(end_y) - DW'(start_y);
  end

  // Stage B: square both differences.
  logic                            vb;
  pal_pkg::side_t                  sb;
  logic signed [pal_pkg::SQ_W-1:0] sqx, sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    sb  <= sa;
    sqx <= sa.dx * sa.dx;
    sqy <= sa.dy * sa.dy;
  end

  // Stage C: sum of squares scaled by 2^(2*FRAC_BITS) forms the radicand.
  logic                       vc;
  pal_pkg::side_t             sc;
  logic [pal_pkg::RAD_W-1:0]  rad;
  logic [pal_pkg::SQ_W-1:0]   sq_sum;

  assign sq_sum = pal_pkg::SQ_W'($unsigned(sqx) + $unsigned(sqy));

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    sc  <= sb;
    rad <= pal_pkg::RAD_W'(sq_sum) << (2 * FB);
  end

  logic                       vr;
  logic [pal_pkg::ROOT_W-1:0] root;
  pal_pkg::side_t             sr;

  pal_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vc),
    .rad       (rad),
    .in_side   (sc),
    .out_valid (vr),
    .root      (root),
    .out_side  (sr)
  );

  // Stage D: pick the length and form the four products.
  logic [LW-1:0]                   len_sel;
  logic                            vd, zd;
  logic [LW-1:0]                   ld;
  logic signed [CW-1:0]            axd, ayd;
  logic signed [pal_pkg::PA_W-1:0] pax, pay;
  logic signed [pal_pkg::PT_W-1:0] ptx, pty;

  assign len_sel = sr.action ? LW'(sr.given) : LW'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vr;
    end
    zd  <= (len_sel == '0);
    ld  <= len_sel;
    axd <= sr.ax;
    ayd <= sr.ay;
    pax <= sr.ax * $signed({1'b0, len_sel});
    pay <= sr.ay * $signed({1'b0, len_sel});
    ptx <= sr.t * sr.dx;
    pty <= sr.t * sr.dy;
  end

  // Stage E: numerator A*L + t*d*2^FRAC_BITS, split into sign and magnitude.
  logic signed [NW-1:0] numx, numy;
  logic                 ve, ze, negx, negy;
  logic [LW-1:0]        le;
  logic [NW-1:0]        magx, magy;
  logic signed [CW-1:0] axe, aye;

  assign numx = NW'(pax) + (NW'(ptx) <<< FB);
  assign numy = NW'(pay) + (NW'(pty) <<< FB);

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= vd;
    end
    ze   <= zd;
    le   <= ld;
    axe  <= axd;
    aye  <= ayd;
    negx <= numx[NW-1];
    negy <= numy[NW-1];
    magx <= numx[NW-1] ? NW'(-numx) : NW'(numx);
    magy <= numy[NW-1] ? NW'(-numy) : NW'(numy);
  end

  logic signed [CW-1:0] qx, qy;
  logic                 satx, saty;

  pal_div u_div_x (
    .clk   (clk),
    .neg   (negx),
    .mag   (magx),
    .len   (le),
    .coord (qx),
    .sat   (satx)
  );

  pal_div u_div_y (
    .clk   (clk),
    .neg   (negy),
    .mag   (magy),
    .len   (le),
    .coord (qy),
    .sat   (saty)
  );

  // The valid bit, the zero flag and A ride past the dividers.
  logic                 vdl [0:DL-1];
  logic                 zdl [0:DL-1];
  logic signed [CW-1:0] xdl [0:DL-1];
  logic signed [CW-1:0] ydl [0:DL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vdl[0] <= 1'b0;
    end else begin
      vdl[0] <= ve;
    end
    zdl[0] <= ze;
    xdl[0] <= axe;
    ydl[0] <= aye;
  end

  for (genvar i = 1; i < DL; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        vdl[i] <= 1'b0;
      end else begin
        vdl[i] <= vdl[i-1];
      end
      zdl[i] <= zdl[i-1];
      xdl[i] <= xdl[i-1];
      ydl[i] <= ydl[i-1];
    end
  end

  // Output register: a zero length overrides the quotient with A.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vdl[DL-1];
    end
    zero_length <= zdl[DL-1];
    point_x     <= zdl[DL-1] ? xdl[DL-1] : qx;
    point_y     <= zdl[DL-1] ? ydl[DL-1] : qy;
    saturated   <= !zdl[DL-1] && (satx || saty);
  end

  // A degenerate segment never reports clamping.
  a_zero_not_sat: assert property (@(posedge clk) disable iff (rst)
    done |-> !(zero_length && saturated))
    else $error("zero_length and saturated both set");

  // A clamped beat has at least one coordinate at a range limit.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (point_x == pal_pkg::COORD_MAX || point_x == pal_pkg::COORD_MIN ||
                             point_y == pal_pkg::COORD_MAX || point_y == pal_pkg::COORD_MIN))
    else $error("saturated beat without a clamped coordinate");

  // A beat leaving the dividers always reaches the output next cycle.
  a_tail_valid: assert property (@(posedge clk) disable iff (rst)
    vdl[DL-1] |=> done)
    else $error("beat lost at the output register");

endmodule

[bench/point_along_line_projection_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_along_line_projection_checker
// Watches start and done beats, predicts each projected point and compares.
// ----------------------------------------------------------------------------
module point_along_line_projection_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic                                   action,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] start_x,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] start_y,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] end_x,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] end_y,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] travel,
  input  logic [pal_pkg::GIVEN_W-1:0]            given_length,
  input  logic                                   done,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [pal_pkg::COORD_WIDTH-1:0] point_y,
  input  logic                                   zero_length,
  input  logic                                   saturated,
  output int                                     fail_count,
  output int                                     pending,
  output int                                     done_count
);

  typedef struct packed {
    logic signed [pal_pkg::COORD_WIDTH-1:0] px;
    logic signed [pal_pkg::COORD_WIDTH-1:0] py;
    logic                                   zl;
    logic                                   sat;
  } point_t;

  point_t projected_q[$];

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One coordinate: exact quotient, truncated toward zero, then clamped.
  function automatic logic signed [pal_pkg::COORD_WIDTH-1:0] clamp_coord(
      longint a, longint d, longint t, longint len, ref logic sat);
    longint num, q;
    num = a * len + ((t * d) <<< pal_pkg::FRAC_BITS);
    q = num / len;
    if (q > longint'(pal_pkg::COORD_MAX)) begin
      sat = 1'b1;
      return pal_pkg::COORD_MAX;
    end
    if (q < longint'(pal_pkg::COORD_MIN)) begin
      sat = 1'b1;
      return pal_pkg::COORD_MIN;
    end
    return q[pal_pkg::COORD_WIDTH-1:0];
  endfunction

  function automatic point_t project(logic act, longint ax, longint ay, longint bx,
                                     longint by, longint t, longint given);
    point_t p;
    longint dx, dy, len;
    logic s;
    dx = bx - ax;
    dy = by - ay;
    s = 1'b0;
    if (!act)
      len = longint'(root_floor(64'(dx * dx + dy * dy) << (2 * pal_pkg::FRAC_BITS)));
    else len = given;
    if (len == 0) begin
      p.px = ax[pal_pkg::COORD_WIDTH-1:0];
      p.py = ay[pal_pkg::COORD_WIDTH-1:0];
      p.zl = 1'b1;
      p.sat = 1'b0;
      return p;
    end
    p.px = clamp_coord(ax, dx, t, len, s);
    p.py = clamp_coord(ay, dy, t, len, s);
    p.zl = 1'b0;
    p.sat = s;
    return p;
  endfunction

  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      projected_q.delete();
      fail_count <= 0;
      done_count <= 0;
    end else begin
      if (start && !busy)
        projected_q.push_back(project(action, start_x, start_y, end_x, end_y, travel,
                                      longint'(given_length)));
      if (done) begin
        done_count <= done_count + 1;
        if (projected_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = projected_q.pop_front();
          if (e.px !== point_x || e.py !== point_y || e.zl !== zero_length
              || e.sat !== saturated) begin
            if (fail_count < 10)
              $display("ERROR: exp x=%0d y=%0d z=%0b s=%0b got x=%0d y=%0d z=%0b s=%0b",
                       e.px, e.py, e.zl, e.sat, point_x, point_y, zero_length, saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = projected_q.size();
  end
endmodule

[bench/point_along_line_projection_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_along_line_projection_top_test
// Directed and random projection beats, sent in bursts, checked by a checker.
// ----------------------------------------------------------------------------
module point_along_line_projection_top_test;

  localparam logic ACT_ROOT  = 1'b0;
  localparam logic ACT_GIVEN = 1'b1;
  localparam int   WATCHDOG  = 2000;
  localparam int   DRAIN     = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, zero_length, saturated;
  logic action = 1'b0;
  logic signed [pal_pkg::COORD_WIDTH-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic signed [pal_pkg::COORD_WIDTH-1:0] travel = '0;
  logic [pal_pkg::GIVEN_W-1:0] given_length = '0;
  logic signed [pal_pkg::COORD_WIDTH-1:0] point_x, point_y;
  int fail_count, pending, done_count;
  int sent = 0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  point_along_line_projection_top uut (.*);
  point_along_line_projection_checker chk (.*);

  // The watchdog counts cycles with neither a start nor a result beat.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("FAIL point_along_line_projection_top");
      $finish;
    end
  end

  // Presents one beat and holds it until the block takes it.
  task automatic send_beat(logic act, logic [15:0] ax, logic [15:0] ay, logic [15:0] bx,
                           logic [15:0] by, logic [15:0] t, logic [pal_pkg::GIVEN_W-1:0] g);
    start <= 1'b1;
    action <= act;
    start_x <= ax;
    start_y <= ay;
    end_x <= bx;
    end_y <= by;
    travel <= t;
    given_length <= g;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random beat: moderate, full-range or zero-length geometry, with given-length mixes.
  task automatic random_beat();
    logic [15:0] ax, ay, bx, by, t;
    logic [pal_pkg::GIVEN_W-1:0] g;
    int mode;
    mode = $urandom_range(0, 9);
    ax = 16'($urandom);
    ay = 16'($urandom);
    t = 16'($urandom);
    if (mode < 4) begin
      bx = ax + 16'($signed($urandom_range(0, 64)) - 32);
      by = ay + 16'($signed($urandom_range(0, 64)) - 32);
      t = 16'($signed($urandom_range(0, 200)) - 100);
    end else begin
      bx = 16'($urandom);
      by = 16'($urandom);
    end
    if (mode == 9) bx = ax;
    if (mode == 9) by = ay;
    case ($urandom_range(0, 3))
      0: g = '0;
      1: g = pal_pkg::GIVEN_W'($urandom_range(1, 4096));
      default: g = pal_pkg::GIVEN_W'($urandom_range(0, 23726080));
    endcase
    if ($urandom_range(0, 15) == 0) g = pal_pkg::GIVEN_W'($urandom);
    send_beat(mode[0] ^ (mode > 6), ax, ay, bx, by, t, g);
  endtask

  initial begin
    int burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed beats: zero length both ways, extremes, negative travel, clamping.
    send_beat(ACT_ROOT, 16'd5, 16'd7, 16'd5, 16'd7, 16'd100, 25'd0);
    send_beat(ACT_GIVEN, 16'h8000, 16'h7fff, 16'd0, 16'd0, 16'd1, 25'd0);
    send_beat(ACT_ROOT, 16'd0, 16'd0, 16'd3, 16'd4, 16'd5, 25'd0);
    send_beat(ACT_ROOT, 16'd0, 16'd0, 16'd3, 16'd4, 16'hfffb, 25'd0);
    send_beat(ACT_ROOT, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 25'd0);
    send_beat(ACT_ROOT, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 25'd0);
    send_beat(ACT_ROOT, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 25'd0);
    send_beat(ACT_GIVEN, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 25'd1);
    send_beat(ACT_GIVEN, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 25'd1);
    send_beat(ACT_GIVEN, 16'd10, 16'd10, 16'd20, 16'd10, 16'd3, 25'd23726080);
    send_beat(ACT_GIVEN, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 25'h1ffffff);
    send_beat(ACT_GIVEN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd9, 25'd256);
    send_beat(ACT_ROOT, 16'd100, 16'hff9c, 16'd101, 16'hff9c, 16'd0, 25'd0);
    send_beat(ACT_ROOT, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'hffff, 25'h1555555);
    pause(3);
    // Random bursts with random gaps, and some long unbroken runs.
    while (sent < 1350) begin
      burst = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 60 : 12);
      repeat (burst) random_beat();
      pause($urandom_range(0, 1) ? 0 : $urandom_range(1, 70));
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d beats, %0d results checked; zero length, clamping and both", sent,
             done_count);
    $display("length sources were exercised with random burst gaps.");
    if (fail_count == 0 && pending == 0) $display("PASS point_along_line_projection_top");
    else $display("FAIL point_along_line_projection_top");
    $finish;
  end
endmodule
